// ===== design/drg_pkg.sv =====
// Shared types and codes for the descriptor ring gather block.
package drg_pkg;

  // Field widths of the input and result words.
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 24;
  localparam int KIND_W = 2;

  // Input opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACK        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COPY       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL_ONES  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FILL_ZEROS = 2'd3;

  // One result word as held in the output register.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] source_address;
    logic [LEN_W-1:0]  chunk_length;
    logic [LEN_W-1:0]  dest_offset;
    logic              release_res;
    logic [ADDR_W-1:0] release_address;
    logic              full_res;
    logic [LEN_W-1:0]  total_count;
    logic              last;
  } out_word_t;

endpackage

// ===== design/drg_in_if.sv =====
// Input channel of the descriptor ring gather block: push and pop words.
interface drg_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [drg_pkg::ADDR_W-1:0] buffer_address;
  logic [drg_pkg::LEN_W-1:0]  byte_count;

  modport source (output valid, output opcode, output buffer_address, output byte_count,
                  input ready);
  modport sink (input valid, input opcode, input buffer_address, input byte_count,
                output ready);
endinterface

// ===== design/drg_out_if.sv =====
// Result channel of the descriptor ring gather block: acknowledge, copy and fill words.
interface drg_out_if;
  logic                       valid;
  logic                       ready;
  logic [drg_pkg::KIND_W-1:0] kind;
  logic [drg_pkg::ADDR_W-1:0] source_address;
  logic [drg_pkg::LEN_W-1:0]  chunk_length;
  logic [drg_pkg::LEN_W-1:0]  dest_offset;
  logic                       release_res;
  logic [drg_pkg::ADDR_W-1:0] release_address;
  logic                       full_res;
  logic [drg_pkg::LEN_W-1:0]  total_count;
  logic                       last;

  modport source (output valid, output kind, output source_address, output chunk_length,
                  output dest_offset, output release_res, output release_address,
                  output full_res, output total_count, output last, input ready);
  modport sink (input valid, input kind, input source_address, input chunk_length,
                input dest_offset, input release_res, input release_address,
                input full_res, input total_count, input last, output ready);
endinterface

// ===== design/descriptor_ring_gather.sv =====
// Descriptor ring gather: a ring of ENTRY_COUNT buffer descriptors with one slot kept free.
// A push word returns one acknowledge word. A pop word is served by a small sequencer that
// walks the ring one descriptor at a time through a shared chunk unit (subtract, compare,
// add): for each descriptor, S_FETCH reads the descriptor memory at the read slot, then
// S_CALC sizes the chunk and emits it. A pop that runs short ends with a zero-fill word,
// and the result side can stall any step. An empty ring answers a pop with one fill-ones
// word. At most ENTRY_COUNT + 1 words come from one pop. The block takes no new word while
// a pop is being walked, nor while a finished word waits in the output register and the
// result side holds it off.
module descriptor_ring_gather #(
  parameter int ENTRY_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  drg_in_if.sink     in_chan,
  drg_out_if.source  out_chan
);

  localparam int SLOT_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int N_W    = $clog2(ENTRY_COUNT + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRY_COUNT - 1);
  localparam logic [N_W-1:0]    N_LIMIT   = N_W'(ENTRY_COUNT);

  localparam int ADDR_W = drg_pkg::ADDR_W;
  localparam int LEN_W  = drg_pkg::LEN_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;

  // Descriptor memory and its registered read port.
  logic [ADDR_W-1:0] addr_mem [ENTRY_COUNT];
  logic [LEN_W-1:0]  len_mem  [ENTRY_COUNT];
  logic [ADDR_W-1:0] rd_addr_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic              mem_we;

  // Control and walk state.
  logic [1:0]             state_r, state_nxt;
  logic [ENTRY_COUNT-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0]      rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0]      wr_slot_r, wr_slot_nxt;
  logic [LEN_W-1:0]       offset_r, offset_nxt;
  logic [LEN_W-1:0]       size_r, size_nxt;
  logic [LEN_W-1:0]       count_r, count_nxt;
  logic [LEN_W-1:0]       want_r, want_nxt;
  logic [N_W-1:0]         n_r, n_nxt;
  logic                   out_valid_r, out_valid_nxt;
  drg_pkg::out_word_t     out_r, out_nxt;

  logic              out_free;
  logic              in_fire;
  logic [SLOT_W-1:0] wr_slot_inc;
  logic [SLOT_W-1:0] rd_slot_inc;
  logic              push_ok;
  logic              push_full;
  logic              ring_empty;
  logic [LEN_W-1:0]  avail;
  logic [LEN_W-1:0]  chunk;
  logic [LEN_W-1:0]  count_new;
  logic              chunk_rel;

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign in_fire = in_chan.valid && in_chan.ready;

  assign wr_slot_inc = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + 1'b1;
  assign rd_slot_inc = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + 1'b1;
  assign push_ok     = (in_chan.buffer_address != '0) && (in_chan.byte_count != '0);
  assign push_full   = push_ok && (wr_slot_inc == rd_slot_r);
  assign ring_empty  = (rd_slot_r == wr_slot_r) && !valid_r[rd_slot_r];
  assign mem_we      = in_fire && (in_chan.opcode == drg_pkg::OP_PUSH) && push_ok && !push_full;

  // Chunk unit: bytes left in the current descriptor, clipped to what the request still wants.
  assign avail     = (rd_len_r > offset_r) ? rd_len_r - offset_r : '0;
  assign chunk_rel = !(avail > want_r);
  assign chunk     = chunk_rel ? avail : want_r;
  assign count_new = count_r + chunk;

  // Descriptor memory: written on an accepted push, read at the read slot every cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      addr_mem[wr_slot_r] <= in_chan.buffer_address;
      len_mem[wr_slot_r]  <= in_chan.byte_count;
    end
    rd_addr_r <= addr_mem[rd_slot_r];
    rd_len_r  <= len_mem[rd_slot_r];
  end

  // Sequencer and result word assembly.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    rd_slot_nxt   = rd_slot_r;
    wr_slot_nxt   = wr_slot_r;
    offset_nxt    = offset_r;
    size_nxt      = size_r;
    count_nxt     = count_r;
    want_nxt      = want_r;
    n_nxt         = n_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          if (in_chan.opcode == drg_pkg::OP_PUSH) begin
            out_nxt.kind     = drg_pkg::KIND_ACK;
            out_nxt.full_res = push_full;
            if (mem_we) begin
              valid_nxt[wr_slot_r] = 1'b1;
              wr_slot_nxt          = wr_slot_inc;
              out_nxt.total_count  = in_chan.byte_count;
            end
          end else if (ring_empty) begin
            out_nxt.kind         = drg_pkg::KIND_FILL_ONES;
            out_nxt.chunk_length = in_chan.byte_count;
          end else begin
            out_valid_nxt = 1'b0;
            size_nxt      = in_chan.byte_count;
            count_nxt     = '0;
            n_nxt         = '0;
            state_nxt     = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        // The read slot's descriptor is being read; decide whether the walk goes on.
        if (out_free) begin
          out_nxt      = '0;
          out_nxt.kind = drg_pkg::KIND_FILL_ZEROS;
          out_nxt.last = 1'b1;
          if (!(count_r < size_r)) begin
            // A zero-byte pop on a ring that holds descriptors.
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (!valid_r[rd_slot_r] || (n_r >= N_LIMIT)) begin
            // Shortfall: zero-fill the rest from the offset reached so far.
            out_nxt.chunk_length = size_r - count_r;
            out_nxt.dest_offset  = count_r;
            out_nxt.total_count  = count_r;
            out_valid_nxt        = 1'b1;
            state_nxt            = S_IDLE;
          end else begin
            want_nxt  = size_r - count_r;
            state_nxt = S_CALC;
          end
        end
      end

      S_CALC: begin
        if (out_free) begin
          out_nxt                 = '0;
          out_nxt.kind            = drg_pkg::KIND_COPY;
          out_nxt.source_address  = rd_addr_r + ADDR_W'(offset_r);
          out_nxt.chunk_length    = chunk;
          out_nxt.dest_offset     = count_r;
          out_nxt.release_res     = chunk_rel;
          out_nxt.release_address = chunk_rel ? rd_addr_r : '0;
          out_nxt.total_count     = count_new;
          out_nxt.last            = !(count_new < size_r);
          out_valid_nxt           = 1'b1;
          count_nxt               = count_new;
          n_nxt                   = n_r + 1'b1;
          if (chunk_rel) begin
            valid_nxt[rd_slot_r] = 1'b0;
            rd_slot_nxt          = rd_slot_inc;
            offset_nxt           = '0;
          end else begin
            offset_nxt = offset_r + chunk;
          end
          state_nxt = (count_new < size_r) ? S_FETCH : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      rd_slot_r   <= '0;
      wr_slot_r   <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rd_slot_r   <= rd_slot_nxt;
      wr_slot_r   <= wr_slot_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    count_r <= count_nxt;
    want_r  <= want_nxt;
    n_r     <= n_nxt;
    out_r   <= out_nxt;
  end

  // Result channel.
  assign out_chan.valid           = out_valid_r;
  assign out_chan.kind            = out_r.kind;
  assign out_chan.source_address  = out_r.source_address;
  assign out_chan.chunk_length    = out_r.chunk_length;
  assign out_chan.dest_offset     = out_r.dest_offset;
  assign out_chan.release_res     = out_r.release_res;
  assign out_chan.release_address = out_r.release_address;
  assign out_chan.full_res        = out_r.full_res;
  assign out_chan.total_count     = out_r.total_count;
  assign out_chan.last            = out_r.last;

endmodule

// ===== tb/tb_descriptor_ring_gather.sv =====
// Self-checking testbench for the descriptor ring gather block.
module tb_descriptor_ring_gather;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W = drg_pkg::ADDR_W;
  localparam int LEN_W  = drg_pkg::LEN_W;

  localparam int ENTRY_COUNT = 16;
  localparam int MAX_WORDS = ENTRY_COUNT + 1;
  localparam int RANDOM_PER_PHASE = 68;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT = 5000;
  localparam int PRINT_CAP = 100;

  // One push or pop request as offered on the input channel.
  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } ring_request_t;

  logic clk;
  logic rst_n;

  drg_in_if  in_chan ();
  drg_out_if out_chan ();

  descriptor_ring_gather #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  ring_request_t      request_queue[$];
  drg_pkg::out_word_t expected_cmds[$];
  int                 error_count = 0;
  int                 words_checked = 0;

  // Idle percentages and the long receiver hold request, changed between phases.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_kicks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Shadow copy of the descriptor ring.
  logic [ADDR_W-1:0] ring_addr [ENTRY_COUNT] = '{default: '0};
  logic [LEN_W-1:0]  ring_len [ENTRY_COUNT] = '{default: '0};
  bit                ring_live [ENTRY_COUNT] = '{default: 1'b0};
  int unsigned       rd_slot = 0;
  int unsigned       wr_slot = 0;
  logic [LEN_W-1:0]  shadow_offset = '0;

  function automatic int unsigned slot_after(int unsigned s);
    return (s + 1 == ENTRY_COUNT) ? 0 : s + 1;
  endfunction

  // Update the shadow ring for one request and queue the words it should produce.
  function automatic void predict_ring_response(ring_request_t r);
    drg_pkg::out_word_t words[$];
    drg_pkg::out_word_t w;
    logic [LEN_W-1:0]   moved;
    logic [LEN_W-1:0]   want;
    logic [LEN_W-1:0]   avail;
    logic [LEN_W-1:0]   piece;
    int unsigned        s;
    moved = '0;
    if (r.op == drg_pkg::OP_PUSH) begin
      w = '0;
      w.kind = drg_pkg::KIND_ACK;
      // Null address or zero length is acknowledged but not stored.
      if (r.addr != '0 && r.len != '0) begin
        if (slot_after(wr_slot) == rd_slot) begin
          w.full_res = 1'b1;
        end else begin
          ring_addr[wr_slot] = r.addr;
          ring_len[wr_slot] = r.len;
          ring_live[wr_slot] = 1'b1;
          wr_slot = slot_after(wr_slot);
          w.total_count = r.len;
        end
      end
      words.push_back(w);
    end else if (rd_slot == wr_slot && !ring_live[rd_slot]) begin
      // Nothing queued: answer with ones for the whole request.
      w = '0;
      w.kind = drg_pkg::KIND_FILL_ONES;
      w.chunk_length = r.len;
      words.push_back(w);
    end else begin
      // Walk the descriptors until the request is met or the ring runs dry.
      while (moved < r.len) begin
        s = rd_slot;
        want = r.len - moved;
        w = '0;
        if (!ring_live[s] || words.size() >= MAX_WORDS - 1) begin
          w.kind = drg_pkg::KIND_FILL_ZEROS;
          w.chunk_length = want;
          w.dest_offset = moved;
          w.total_count = moved;
          words.push_back(w);
          break;
        end
        avail = (ring_len[s] > shadow_offset) ? ring_len[s] - shadow_offset : '0;
        piece = (avail > want) ? want : avail;
        w.kind = drg_pkg::KIND_COPY;
        w.source_address = ring_addr[s] + ADDR_W'(shadow_offset);
        w.chunk_length = piece;
        w.dest_offset = moved;
        moved = moved + piece;
        shadow_offset = shadow_offset + piece;
        w.total_count = moved;
        if (shadow_offset >= ring_len[s]) begin
          w.release_res = 1'b1;
          w.release_address = ring_addr[s];
          ring_addr[s] = '0;
          ring_len[s] = '0;
          ring_live[s] = 1'b0;
          shadow_offset = '0;
          rd_slot = slot_after(s);
        end
        words.push_back(w);
      end
      // A zero-byte pop on a non-empty ring still gets one empty zero-fill.
      if (words.size() == 0) begin
        w = '0;
        w.kind = drg_pkg::KIND_FILL_ZEROS;
        words.push_back(w);
      end
    end
    words[words.size() - 1].last = 1'b1;
    foreach (words[i]) expected_cmds.push_back(words[i]);
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < PRINT_CAP) $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] seen, logic [ADDR_W-1:0] want);
    if (seen !== want) begin
      report_mismatch($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                words_checked, name, seen, want));
    end
  endtask

  function automatic ring_request_t random_request();
    ring_request_t r;
    int            pick;
    pick = $urandom_range(99);
    r.addr = $urandom;
    if (pick < 6) begin
      // Noise: a push that the ring ignores.
      r.op = drg_pkg::OP_PUSH;
      if ($urandom_range(1) == 1) begin
        r.addr = '0;
        r.len = LEN_W'($urandom);
      end else begin
        r.len = '0;
      end
    end else if (pick < 55) begin
      r.op = drg_pkg::OP_PUSH;
      if (r.addr == '0) r.addr = 32'h1;
      r.len = ($urandom_range(9) < 8) ? LEN_W'($urandom_range(64, 1)) : LEN_W'($urandom);
    end else begin
      r.op = drg_pkg::OP_POP;
      pick = $urandom_range(9);
      if (pick < 7) r.len = LEN_W'($urandom_range(96));
      else if (pick < 9) r.len = LEN_W'($urandom_range(1024, 1));
      else r.len = LEN_W'($urandom);
    end
    return r;
  endfunction

  function automatic void queue_request(logic op, logic [ADDR_W-1:0] addr,
                                        logic [LEN_W-1:0] len);
    ring_request_t r;
    r.op = op;
    r.addr = addr;
    r.len = len;
    request_queue.push_back(r);
  endfunction

  task automatic wait_for_drain();
    while (request_queue.size() != 0 || expected_cmds.size() != 0) @(negedge clk);
  endtask

  // Clock, and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = drg_pkg::OP_PUSH;
    in_chan.buffer_address = '0;
    in_chan.byte_count = '0;
    out_chan.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: predicts on acceptance, then offers the next queued word.
  always @(posedge clk) begin : drive_requests
    ring_request_t nxt;
    bit            taken;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      taken = in_chan.valid && in_chan.ready;
      if (taken) begin
        nxt = request_queue.pop_front();
        predict_ring_response(nxt);
      end
      // An offered word stays on the bus until the block takes it.
      if (!in_chan.valid || taken) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = request_queue[0];
          in_chan.valid <= 1'b1;
          in_chan.opcode <= nxt.op;
          in_chan.buffer_address <= nxt.addr;
          in_chan.byte_count <= nxt.len;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, plus a long hold whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else if (hold_kicks != hold_seen) begin
      hold_seen = hold_kicks;
      hold_left = LONG_HOLD - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result monitor: each accepted word is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    drg_pkg::out_word_t got;
    drg_pkg::out_word_t exp;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.kind = out_chan.kind;
      got.source_address = out_chan.source_address;
      got.chunk_length = out_chan.chunk_length;
      got.dest_offset = out_chan.dest_offset;
      got.release_res = out_chan.release_res;
      got.release_address = out_chan.release_address;
      got.full_res = out_chan.full_res;
      got.total_count = out_chan.total_count;
      got.last = out_chan.last;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected word, kind %0d", got.kind));
      end else begin
        exp = expected_cmds.pop_front();
        check_field("kind", ADDR_W'(got.kind), ADDR_W'(exp.kind));
        check_field("source_address", got.source_address, exp.source_address);
        check_field("chunk_length", ADDR_W'(got.chunk_length), ADDR_W'(exp.chunk_length));
        check_field("dest_offset", ADDR_W'(got.dest_offset), ADDR_W'(exp.dest_offset));
        check_field("release_res", ADDR_W'(got.release_res), ADDR_W'(exp.release_res));
        check_field("release_address", got.release_address, exp.release_address);
        check_field("full_res", ADDR_W'(got.full_res), ADDR_W'(exp.full_res));
        check_field("total_count", ADDR_W'(got.total_count), ADDR_W'(exp.total_count));
        check_field("last", ADDR_W'(got.last), ADDR_W'(exp.last));
      end
      words_checked++;
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_descriptor_ring_gather: done, errors");
    $finish;
  end

  // Stimulus sequence.
  initial begin : stimulus
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-ring pops, ignored pushes, extreme fields and address wrap.
    queue_request(drg_pkg::OP_POP, 32'h0, 24'd100);
    queue_request(drg_pkg::OP_POP, 32'hFFFF_FFFF, 24'd0);
    queue_request(drg_pkg::OP_PUSH, 32'h0, 24'd10);
    queue_request(drg_pkg::OP_PUSH, 32'h0000_1000, 24'd0);
    queue_request(drg_pkg::OP_PUSH, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_request(drg_pkg::OP_PUSH, 32'h0000_1000, 24'h10);
    queue_request(drg_pkg::OP_POP, 32'h0, 24'd0);
    queue_request(drg_pkg::OP_POP, 32'h0, 24'd5);
    queue_request(drg_pkg::OP_POP, 32'h0, 24'hFF_FFFF);
    // This one runs past the last descriptor and ends in a zero-fill.
    queue_request(drg_pkg::OP_POP, 32'h0, 24'h20);
    // Fill the ring until a push is turned away, then drain it in one pop.
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      queue_request(drg_pkg::OP_PUSH, 32'h8000_0000 + 32'(i) * 32'h100, LEN_W'(i + 1));
    end
    queue_request(drg_pkg::OP_POP, 32'h0, 24'hFF_FFFF);
    wait_for_drain();

    // Random phases; the sender waits for every result between phases.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          // Long receiver hold while the sender keeps offering.
          hold_kicks++;
        end
        1: begin
          src_idle_pct = 50;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 50;
        end
        default: begin
          src_idle_pct = 25;
          sink_stall_pct = 25;
        end
      endcase
      repeat (RANDOM_PER_PHASE) request_queue.push_back(random_request());
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_descriptor_ring_gather: done, clean");
    end else begin
      $display("tb_descriptor_ring_gather: done, errors");
    end
    $finish;
  end

endmodule
